// ----- hw/rtl/uwc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uwc_pkg
// Types and constants shared by the whitespace collapser modules.
// ----------------------------------------------------------------------------
package uwc_pkg;

    localparam int CODE_W    = 21;
    localparam int GROUP_MAX = 6;
    localparam int CNT_W     = $clog2(GROUP_MAX + 1);

    localparam logic [CODE_W-1:0] CP_REPL  = 21'h00FFFD;
    localparam logic [CODE_W-1:0] CP_NBSP  = 21'h0000A0;
    localparam logic [CODE_W-1:0] CP_SPACE = 21'h000020;
    localparam logic [CODE_W-1:0] CP_DASH  = 21'h00002D;
    localparam logic [CODE_W-1:0] CP_TAB   = 21'h000009;
    localparam logic [CODE_W-1:0] CP_CR    = 21'h00000D;
    localparam logic [7:0]        BYTE_SPACE = 8'h20;

    // one accepted input byte
    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } in_item_t;

    // one result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       text_end;
    } out_item_t;

    // all result items caused by one input byte
    typedef struct packed {
        logic [GROUP_MAX-2:0][7:0] bytes;
        logic [CNT_W-1:0]          nbytes;
        logic                      has_end;
    } group_t;

endpackage

// ----- hw/rtl/uwc_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uwc_stream_if
// Valid/ready channel carrying one payload word per transfer.
// ----------------------------------------------------------------------------
interface uwc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/uwc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uwc_front
// UTF-8 decode state, whitespace collapse state and re-encode of one byte
// into its group of result items.
// ----------------------------------------------------------------------------
module uwc_front import uwc_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     take,
    input  in_item_t item,
    output group_t   group
);

    logic [1:0]        owed_reg, owed_next;
    logic [CODE_W-1:0] accum_reg, accum_next;
    logic              any_reg, any_next;
    logic              space_reg, space_next;

    logic [7:0]        b;
    logic              last;
    logic [1:0]        owed_dec;
    logic [CODE_W-1:0] accum_shift;
    logic              emit;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] cp;
    logic              white;
    logic [3:0][7:0]   enc;
    logic [2:0]        enc_n;

    assign b           = item.in_byte;
    assign last        = item.last_byte;
    assign owed_dec    = owed_reg - 2'd1;
    assign accum_shift = {accum_reg[CODE_W-7:0], b[5:0]};

    // decode step
    always_comb
    begin
        emit       = 1'b0;
        code       = CP_REPL;
        owed_next  = owed_reg;
        accum_next = accum_reg;
        if (owed_reg != 2'd0)
        begin
            accum_next = accum_shift;
            owed_next  = owed_dec;
            if (owed_dec == 2'd0)
            begin
                emit = 1'b1;
                code = accum_shift;
            end
            else if (last)
            begin
                emit = 1'b1;
            end
        end
        else
        begin
            priority if (b[7] == 1'b0)
            begin
                emit = 1'b1;
                code = {{(CODE_W-8){1'b0}}, b};
            end
            else if (b[7:5] == 3'b110)
            begin
                accum_next = {{(CODE_W-5){1'b0}}, b[4:0]};
                owed_next  = 2'd1;
                emit       = last;
            end
            else if (b[7:4] == 4'b1110)
            begin
                accum_next = {{(CODE_W-4){1'b0}}, b[3:0]};
                owed_next  = 2'd2;
                emit       = last;
            end
            else if (b[7:3] == 5'b11110)
            begin
                accum_next = {{(CODE_W-3){1'b0}}, b[2:0]};
                owed_next  = 2'd3;
                emit       = last;
            end
            else
            begin
                emit = 1'b1;
            end
        end
    end

    // replacement character maps to a dash
    assign cp    = (code == CP_REPL) ? CP_DASH : code;
    assign white = (cp >= CP_TAB && cp <= CP_CR) || cp == CP_SPACE || cp == CP_NBSP;

    // re-encode the code point
    always_comb
    begin
        enc = '0;
        priority if (cp[CODE_W-1:7] == '0)
        begin
            enc[0] = cp[7:0];
            enc_n  = 3'd1;
        end
        else if (cp[CODE_W-1:11] == '0)
        begin
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
            enc_n  = 3'd2;
        end
        else if (cp[CODE_W-1:16] == '0)
        begin
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
            enc_n  = 3'd3;
        end
        else
        begin
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
            enc_n  = 3'd4;
        end
    end

    // collapse whitespace and build the result group
    always_comb
    begin
        group      = '0;
        space_next = space_reg;
        any_next   = any_reg;
        if (emit)
        begin
            if (white)
            begin
                space_next = any_reg;
            end
            else
            begin
                any_next   = 1'b1;
                space_next = 1'b0;
                if (space_reg)
                begin
                    group.bytes[0] = BYTE_SPACE;
                    for (int i = 0; i < 4; i++)
                    begin
                        group.bytes[i+1] = enc[i];
                    end
                    group.nbytes = CNT_W'(enc_n) + CNT_W'(1);
                end
                else
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        group.bytes[i] = enc[i];
                    end
                    group.nbytes = CNT_W'(enc_n);
                end
            end
        end
        group.has_end = last;
    end

    // decode and collapse state, cleared after the end of a text
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owed_reg  <= '0;
            accum_reg <= '0;
            any_reg   <= 1'b0;
            space_reg <= 1'b0;
        end
        else if (take)
        begin
            if (last)
            begin
                owed_reg  <= '0;
                accum_reg <= '0;
                any_reg   <= 1'b0;
                space_reg <= 1'b0;
            end
            else
            begin
                owed_reg  <= owed_next;
                accum_reg <= accum_next;
                any_reg   <= any_next;
                space_reg <= space_next;
            end
        end
    end

endmodule

// ----- hw/rtl/uwc_serializer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uwc_serializer
// Output register that sends a result group one item per transfer.
// ----------------------------------------------------------------------------
module uwc_serializer import uwc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  group_t             group,
    output logic               can_load,
    uwc_stream_if.source       clean
);

    group_t           grp_reg;
    logic [CNT_W-1:0] idx_reg;
    logic             valid_reg;

    logic [CNT_W-1:0] total;
    logic             last_item;
    logic             data_item;

    assign total     = grp_reg.nbytes + CNT_W'(grp_reg.has_end);
    assign last_item = (idx_reg == total - CNT_W'(1));
    assign data_item = (idx_reg < grp_reg.nbytes);
    assign can_load  = !valid_reg || (clean.ready && last_item);

    // current item of the group
    assign clean.valid              = valid_reg;
    assign clean.payload.out_byte   = data_item ? grp_reg.bytes[idx_reg] : 8'h00;
    assign clean.payload.byte_valid = data_item;
    assign clean.payload.run_last   = last_item;
    assign clean.payload.text_end   = !data_item;

    // group payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            grp_reg <= group;
        end
    end

    // item index and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b1;
        end
        else if (valid_reg && clean.ready)
        begin
            if (last_item)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
        end
    end

endmodule

// ----- hw/rtl/utf8_whitespace_collapser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_whitespace_collapser
// Permissive UTF-8 decode, whitespace collapse and re-encode of one text.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle on raw while raw.ready is high and
// writes the cleaned UTF-8 stream on clean, one result item per cycle while
// clean.ready is high, ending each text with a marker item (byte_valid low,
// text_end high). A byte is decoded, collapsed and re-encoded in the cycle
// it is transferred; the group of zero to six result items it causes is held
// in a skid register and then in the output register, which sends one item
// per cycle while clean is ready, so a byte that causes several items holds
// the output until all are sent; raw stays ready as long as the skid register
// is free, so bytes that cause one item or none flow at one per cycle then.
module utf8_whitespace_collapser import uwc_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    uwc_stream_if.sink   raw,
    uwc_stream_if.source clean
);

    group_t group;
    group_t grp_a_reg;
    logic   a_valid_reg;
    logic   take;
    logic   nonempty;
    logic   ser_can_load;
    logic   ser_load;

    assign ser_load  = a_valid_reg && ser_can_load;
    assign raw.ready = !a_valid_reg || ser_can_load;
    assign take      = raw.valid && raw.ready;
    assign nonempty  = (group.nbytes != '0) || group.has_end;

    // decode, collapse and encode
    uwc_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (raw.payload),
        .group (group)
    );

    // skid register payload
    always_ff @(posedge clk)
    begin
        if (take && nonempty)
        begin
            grp_a_reg <= group;
        end
    end

    // skid register occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (take && nonempty)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (ser_load)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    // output register and item sequencing
    uwc_serializer u_serializer (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (ser_load),
        .group    (grp_a_reg),
        .can_load (ser_can_load),
        .clean    (clean)
    );

    // end marker is always the last item of its group
    assert property (@(posedge clk) disable iff (!rst_n)
        clean.valid && clean.payload.text_end |-> clean.payload.run_last)
        else $error("end marker without run_last");

    // final byte always leaves a group behind
    assert property (@(posedge clk) disable iff (!rst_n)
        take && raw.payload.last_byte |=> a_valid_reg)
        else $error("final byte produced no group");

    // a waiting group holds until the output register takes it
    assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !ser_can_load |=> a_valid_reg && $stable(grp_a_reg))
        else $error("skid group lost while output busy");

endmodule
